@@ sv/brct_pkg.sv @@
// Package: types and constants for the region capture table.
`timescale 1ns / 1ps
package brct_pkg;
  localparam int unsigned AddrW = 64;
  localparam int unsigned LenW = 17;
  localparam int unsigned OffW = 32;
  localparam int unsigned TotW = 32;
  localparam int unsigned StatW = 4;
  localparam int unsigned KernelShift = 56;
  localparam logic [LenW-1:0] LenMax = 17'd65536;

  localparam logic [1:0] RegPageShift = 2'd0;
  localparam logic [1:0] RegWindow = 2'd1;
  localparam logic [1:0] RegBudget = 2'd2;

  typedef enum logic [StatW-1:0] {
    ST_REQ = 4'd0, ST_CAP = 4'd1, ST_LOW = 4'd2, ST_KERNEL = 4'd3,
    ST_UNWRITABLE = 4'd4, ST_NOBUDGET = 4'd5, ST_OVERLAP = 4'd6,
    ST_INSERTED = 4'd7, ST_READFAIL = 4'd8, ST_WRITEFAIL = 4'd9,
    ST_NOPENDING = 4'd10
  } status_e;

  typedef struct packed {
    logic [AddrW-1:0] range_start;
    logic [AddrW-1:0] range_end;
    logic [OffW-1:0] range_offset;
    logic [LenW-1:0] range_size;
  } entry_t;

  typedef struct packed {
    logic cmd;
    logic [AddrW-1:0] addr;
    logic writable;
    logic [LenW-1:0] got_bytes;
    logic [OffW-1:0] write_offset;
  } in_item_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [AddrW-1:0] read_start;
    logic [LenW-1:0] read_len;
    logic [6:0] regions_held;
    logic [TotW-1:0] bytes_used;
    logic walk_done;
  } out_item_t;

  typedef struct packed {
    logic [1:0] index;
    logic [TotW-1:0] data;
  } cfg_item_t;
endpackage

@@ sv/brct_if.sv @@
// Interfaces: valid/ready channels for items, results and configuration.
`timescale 1ns / 1ps
interface brct_in_if;
  logic valid;
  logic ready;
  brct_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface brct_out_if;
  logic valid;
  logic ready;
  brct_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface brct_cfg_if;
  logic valid;
  logic ready;
  brct_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/brct_ram.sv @@
// Entry memory: one write port and one registered read port.
`timescale 1ns / 1ps
module brct_ram #(
  parameter int unsigned Depth = 64
) (
  input  logic clk_i,
  input  logic we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  brct_pkg::entry_t wdata_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output brct_pkg::entry_t rdata_o
);
  brct_pkg::entry_t mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ sv/budgeted_region_capture_table.sv @@
// Top level: region capture table with filtering, overlap search and sorted insert.
//
//  channel  dir  payload
//  in_ch    in   cmd, addr, writable, got_bytes, write_offset
//  out_ch   out  status, read_start, read_len, regions_held, bytes_used, walk_done
//  cfg_ch   in   index, data (page_shift, window_bytes, byte_budget)
//
// One item at a time. A consider runs a binary search over the table; each probe
// takes an address step and a compare step on the single memory read port.
// A commit runs the search too, plus a read and then a write through the one
// memory for each entry shifted by the insert. The result sits in an output
// register; the next item is taken only once it has been delivered. Reset
// clears counters and pending state; no sweep.
`timescale 1ns / 1ps
module budgeted_region_capture_table #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input logic clk_i,
  input logic rst_ni,
  brct_in_if.sink in_ch,
  brct_out_if.source out_ch,
  brct_cfg_if.sink cfg_ch
);
  localparam int unsigned IdxW = $clog2(MAX_ENTRIES > 1 ? MAX_ENTRIES : 2);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CALC   = 8'b0000_0010,
    S_TRIM   = 8'b0000_0100,
    S_PROBE  = 8'b0000_1000,
    S_CMP    = 8'b0001_0000,
    S_SHRD   = 8'b0010_0000,
    S_SHWR   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [4:0] page_shift_q;
  logic [brct_pkg::LenW-1:0] window_q;
  logic [brct_pkg::TotW-1:0] budget_q;

  logic [CntW-1:0] count_q;
  logic [brct_pkg::TotW-1:0] total_q;
  logic [brct_pkg::AddrW-1:0] pend_start_q;
  logic [brct_pkg::LenW-1:0] pend_len_q;
  logic pend_valid_q;

  brct_pkg::in_item_t item_q;
  logic [brct_pkg::AddrW-1:0] start_q, end_q;
  logic [brct_pkg::AddrW-1:0] want_q;
  logic [brct_pkg::LenW-1:0] got_q;
  logic [CntW-1:0] lo_q, hi_q, ptr_q;
  logic out_valid_q;
  brct_pkg::out_item_t out_q;
  logic probe_wait_q;

  logic ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  brct_pkg::entry_t ram_wdata, ram_rdata;

  brct_ram #(.Depth(MAX_ENTRIES)) u_ram (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  logic [brct_pkg::AddrW-1:0] page, mask;
  assign page = 64'd1 << page_shift_q;
  assign mask = ~(page - 64'd1);

  logic limits;
  assign limits = ({1'b0, total_q} >= {1'b0, budget_q}) ||
                  ({1'b0, count_q} >= (CntW+1)'(MAX_ENTRIES));

  logic [CntW-1:0] mid;
  assign mid = CntW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

  logic search_done;
  assign search_done = (lo_q == hi_q);

  logic search_overlap;
  assign search_overlap = (lo_q < count_q) && (ram_rdata.range_start < end_q);

  assign in_ch.ready = (state_q == S_IDLE) && !out_valid_q;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_q;
  assign out_ch.data = out_q;

  // Memory read address: probe at mid, shift reads the entry below ptr.
  always_comb begin
    ram_raddr = mid[IdxW-1:0];
    if (state_q == S_SHRD) begin
      ram_raddr = IdxW'(ptr_q - CntW'(1));
    end
  end

  logic [brct_pkg::LenW-1:0] got_clamp;
  assign got_clamp = (item_q.got_bytes < pend_len_q) ? item_q.got_bytes : pend_len_q;

  logic [brct_pkg::AddrW-1:0] remaining;
  assign remaining = {32'd0, budget_q} - {32'd0, total_q};

  logic [brct_pkg::AddrW:0] total_sum;
  assign total_sum = {33'd0, total_q} + {48'd0, got_q};

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = ptr_q[IdxW-1:0];
    ram_wdata = ram_rdata;
    if (state_q == S_SHWR) begin
      ram_we = 1'b1;
      if (ptr_q == lo_q) begin
        ram_wdata.range_start = pend_start_q;
        ram_wdata.range_end = pend_start_q + {47'd0, got_q};
        ram_wdata.range_offset = item_q.write_offset;
        ram_wdata.range_size = got_q;
      end
    end
  end

  logic [brct_pkg::StatW-1:0] fin_status;
  logic fin;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_d = S_CALC;
      S_CALC: state_d = (fin) ? S_OUT : S_TRIM;
      S_TRIM: state_d = (fin) ? S_OUT : S_PROBE;
      S_PROBE: state_d = search_done ? S_CMP : S_PROBE;
      S_CMP: state_d = item_q.cmd ? S_SHRD : S_OUT;
      S_SHRD: state_d = S_SHWR;
      S_SHWR: state_d = (ptr_q == lo_q) ? S_OUT : S_SHRD;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Early finish decisions for CALC (filters) and TRIM (budget).
  always_comb begin
    fin = 1'b0;
    fin_status = brct_pkg::ST_REQ;
    if (state_q == S_CALC) begin
      fin = 1'b1;
      if (!item_q.cmd) begin
        if (limits) fin_status = brct_pkg::ST_CAP;
        else if (item_q.addr < page) fin_status = brct_pkg::ST_LOW;
        else if ((item_q.addr >> brct_pkg::KernelShift) != 64'd0)
          fin_status = brct_pkg::ST_KERNEL;
        else if (!item_q.writable) fin_status = brct_pkg::ST_UNWRITABLE;
        else fin = 1'b0;
      end else begin
        if (!pend_valid_q) fin_status = brct_pkg::ST_NOPENDING;
        else if (got_clamp == '0) fin_status = brct_pkg::ST_READFAIL;
        else if (item_q.write_offset == '0) fin_status = brct_pkg::ST_WRITEFAIL;
        else if ({1'b0, count_q} >= (CntW+1)'(MAX_ENTRIES)) fin_status = brct_pkg::ST_CAP;
        else fin = 1'b0;
      end
    end else if (state_q == S_TRIM && !item_q.cmd) begin
      if (want_q > remaining && (start_q + remaining <= start_q)) begin
        fin = 1'b1;
        fin_status = brct_pkg::ST_NOBUDGET;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      page_shift_q <= 5'd12;
      window_q <= 17'd1024;
      budget_q <= 32'd1048576;
      count_q <= '0;
      total_q <= '0;
      pend_start_q <= '0;
      pend_len_q <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_ch.valid) begin
        case (cfg_ch.data.index)
          brct_pkg::RegPageShift: page_shift_q <= cfg_ch.data.data[4:0];
          brct_pkg::RegWindow: window_q <= cfg_ch.data.data[16:0];
          brct_pkg::RegBudget: budget_q <= cfg_ch.data.data;
          default: ;
        endcase
      end
      if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
      if (state_q == S_OUT) out_valid_q <= 1'b1;
      if (state_q == S_CALC && item_q.cmd && pend_valid_q) pend_valid_q <= 1'b0;
      if (state_q == S_CMP && !item_q.cmd && (search_overlap == 1'b0)) begin
        pend_start_q <= start_q;
        pend_len_q <= want_q[brct_pkg::LenW-1:0];
        pend_valid_q <= 1'b1;
      end
      if (state_q == S_SHWR && ptr_q == lo_q) begin
        count_q <= count_q + CntW'(1);
        total_q <= (total_sum > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : total_sum[31:0];
      end
    end
  end

  logic [brct_pkg::AddrW-1:0] ws, we_raw;
  assign ws = (item_q.addr - {48'd0, window_q[16:1]}) & mask;
  assign we_raw = ((ws + {47'd0, window_q}) + page - 64'd1) & mask;

  // Datapath; payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) item_q <= in_ch.data;
    case (state_q)
      S_CALC: begin
        if (item_q.cmd) begin
          start_q <= pend_start_q;
          got_q <= got_clamp;
        end else begin
          start_q <= ws;
          want_q <= ((we_raw - ws) > 64'd65536) ? 64'd65536 : (we_raw - ws);
        end
        lo_q <= '0;
        hi_q <= count_q;
        out_q.status <= fin_status;
        out_q.read_start <= '0;
        out_q.read_len <= '0;
      end
      S_TRIM: begin
        if (!item_q.cmd) begin
          if (want_q > remaining) begin
            want_q <= remaining;
            end_q <= start_q + remaining;
          end else begin
            end_q <= start_q + want_q;
          end
        end
        out_q.status <= fin_status;
      end
      S_PROBE: begin
        // Probes alternate: issue read here, compare on the next visit.
        if (!search_done && probe_wait_q) begin
          if (ram_rdata.range_end <= start_q) lo_q <= mid + CntW'(1);
          else hi_q <= mid;
        end
      end
      S_CMP: begin
        if (!item_q.cmd) begin
          if (search_overlap) begin
            out_q.status <= brct_pkg::ST_OVERLAP;
          end else begin
            out_q.status <= brct_pkg::ST_REQ;
            out_q.read_start <= start_q;
            out_q.read_len <= want_q[brct_pkg::LenW-1:0];
          end
        end else begin
          out_q.status <= brct_pkg::ST_INSERTED;
          ptr_q <= count_q;
        end
      end
      S_SHWR: if (ptr_q != lo_q) ptr_q <= ptr_q - CntW'(1);
      default: ;
    endcase
    if (state_q == S_OUT) begin
      out_q.regions_held <= 7'(count_q);
      out_q.bytes_used <= total_q;
      out_q.walk_done <= limits;
    end
  end

  // Alternate probe cycles: address then compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) probe_wait_q <= 1'b0;
    else if (state_q == S_PROBE && !search_done) probe_wait_q <= !probe_wait_q;
    else probe_wait_q <= 1'b0;
  end
endmodule

@@ sv/brct_checker.sv @@
// Checker: port-level properties of the capture table, bound to the top level.
`timescale 1ns / 1ps
module brct_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input brct_pkg::out_item_t out_data
);
  // No new transaction is taken while a result waits.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("input ready right after accept");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.status != brct_pkg::ST_REQ |-> out_data.read_len == '0)
    else $error("read_len set without request");
  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.read_len <= brct_pkg::LenMax) else $error("read_len too large");
endmodule

bind budgeted_region_capture_table brct_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

@@ tb/tb_budgeted_region_capture_table.sv @@
// Testbench: randomized regression of the region capture table against a local predictor.
`timescale 1ns / 1ps
module tb_budgeted_region_capture_table;
  localparam int unsigned Entries = 64;
  localparam int unsigned WatchLimit = 200000;

  logic clk_i;
  logic rst_ni;

  brct_in_if in_ch ();
  brct_out_if out_ch ();
  brct_cfg_if cfg_ch ();

  budgeted_region_capture_table #(.MAX_ENTRIES(Entries)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predictor state.
  logic [4:0] page_shift_q;
  logic [16:0] window_q;
  logic [31:0] budget_q;
  logic [63:0] tbl_start [Entries];
  logic [63:0] tbl_end [Entries];
  int unsigned tbl_count;
  logic [31:0] total_q;
  logic [63:0] pend_start;
  logic [16:0] pend_len;
  logic pend_valid;

  brct_pkg::in_item_t pending_items[$];
  brct_pkg::out_item_t expected_results[$];
  int unsigned mismatches;
  bit sender_hold;
  bit receiver_hold;
  int unsigned idle_cycles;

  function automatic int unsigned first_end_above(logic [63:0] target);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_end[mid] <= target) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic bit limits_reached();
    return ({32'd0, total_q} >= {32'd0, budget_q}) || (tbl_count >= Entries);
  endfunction

  function automatic brct_pkg::out_item_t predict_capture(brct_pkg::in_item_t it);
    brct_pkg::out_item_t r;
    logic [63:0] page, mask, start, stop, want, remaining;
    logic [16:0] got;
    int unsigned idx;
    logic [32:0] sum;
    r = '0;
    if (it.cmd) begin
      if (!pend_valid) r.status = brct_pkg::ST_NOPENDING;
      else begin
        pend_valid = 1'b0;
        got = (it.got_bytes < pend_len) ? it.got_bytes : pend_len;
        if (got == 0) r.status = brct_pkg::ST_READFAIL;
        else if (it.write_offset == 0) r.status = brct_pkg::ST_WRITEFAIL;
        else if (tbl_count >= Entries) r.status = brct_pkg::ST_CAP;
        else begin
          idx = first_end_above(pend_start);
          for (int k = tbl_count; k > idx; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_end[k] = tbl_end[k-1];
          end
          tbl_start[idx] = pend_start;
          tbl_end[idx] = pend_start + {47'd0, got};
          tbl_count++;
          sum = {1'b0, total_q} + {16'd0, got};
          total_q = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          r.status = brct_pkg::ST_INSERTED;
        end
      end
    end else begin
      page = 64'd1 << page_shift_q;
      mask = ~(page - 64'd1);
      if (limits_reached()) r.status = brct_pkg::ST_CAP;
      else if (it.addr < page) r.status = brct_pkg::ST_LOW;
      else if ((it.addr >> brct_pkg::KernelShift) != 0) r.status = brct_pkg::ST_KERNEL;
      else if (!it.writable) r.status = brct_pkg::ST_UNWRITABLE;
      else begin
        start = (it.addr - {48'd0, window_q[16:1]}) & mask;
        stop = (start + {47'd0, window_q} + page - 64'd1) & mask;
        want = stop - start;
        if (want > 64'd65536) want = 64'd65536;
        remaining = {32'd0, budget_q} - {32'd0, total_q};
        r.status = brct_pkg::ST_REQ;
        if (want > remaining) begin
          want = remaining;
          if (start + want <= start) r.status = brct_pkg::ST_NOBUDGET;
        end
        if (r.status == brct_pkg::ST_REQ) begin
          stop = start + want;
          idx = first_end_above(start);
          if (idx < tbl_count && tbl_start[idx] < stop) r.status = brct_pkg::ST_OVERLAP;
          else begin
            pend_start = start;
            pend_len = want[16:0];
            pend_valid = 1'b1;
            r.read_start = start;
            r.read_len = want[16:0];
          end
        end
      end
    end
    r.regions_held = tbl_count[6:0];
    r.bytes_used = total_q;
    r.walk_done = limits_reached();
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Input driver; also resets the predictor's table state.
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      in_gap = 0;
      tbl_count = 0;
      total_q = '0;
      pend_start = '0;
      pend_len = '0;
      pend_valid = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_capture(in_ch.data));
        void'(pending_items.pop_front());
        in_gap = ($urandom_range(0, 3) == 0) ?
                 (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
      end
      if (in_gap > 0) in_gap--;
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered transaction
      end else if (pending_items.size() > 0 && in_gap == 0 && !sender_hold
                   && !(in_ch.valid && in_ch.ready && pending_items.size() == 0)) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_items[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver.
  int unsigned out_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    brct_pkg::out_item_t exp_r;
    brct_pkg::out_item_t got_r;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_r = out_ch.data;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got_r);
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", exp_r, got_r);
          end
        end
        out_gap = ($urandom_range(0, 3) == 0) ?
                  (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
      end
      if (out_gap > 0) out_gap--;
      out_ch.ready <= (out_gap == 0) && !receiver_hold;
    end
  end

  // Watchdog on accepted transactions.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("budgeted_region_capture_table regression: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_ch.valid) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] index, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: index, data: value};
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    case (index)
      brct_pkg::RegPageShift: page_shift_q = value[4:0];
      brct_pkg::RegWindow: window_q = value[16:0];
      brct_pkg::RegBudget: budget_q = value;
      default: ;
    endcase
  endtask

  function automatic brct_pkg::in_item_t consider_item(logic [63:0] addr, logic writable);
    brct_pkg::in_item_t it;
    it = '0;
    it.cmd = 1'b0;
    it.addr = addr;
    it.writable = writable;
    it.got_bytes = 17'($urandom);
    it.write_offset = $urandom;
    return it;
  endfunction

  function automatic brct_pkg::in_item_t commit_item(logic [16:0] got, logic [31:0] off);
    brct_pkg::in_item_t it;
    it = '0;
    it.cmd = 1'b1;
    it.addr = {$urandom, $urandom};
    it.writable = 1'($urandom_range(0, 1));
    it.got_bytes = got;
    it.write_offset = off;
    return it;
  endfunction

  function automatic logic [63:0] heap_addr();
    logic [63:0] a;
    a = {8'd0, 24'($urandom_range(0, 3)), 32'($urandom)};
    if ($urandom_range(0, 9) == 0) a = {8'd0, 24'($urandom), $urandom};
    return a;
  endfunction

  function automatic logic [16:0] random_got();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom);
      default: return 17'($urandom_range(1, 70000));
    endcase
  endfunction

  task automatic random_phase(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0: pending_items.push_back(consider_item({$urandom, $urandom},
                                                 1'($urandom_range(0, 1))));
        1: pending_items.push_back(consider_item(64'($urandom_range(0, 8191)), 1'b1));
        2: pending_items.push_back(consider_item(heap_addr(), 1'b0));
        3: pending_items.push_back(commit_item(random_got(), $urandom));
        default: begin
          pending_items.push_back(consider_item(heap_addr(), 1'b1));
          pending_items.push_back(commit_item(random_got(),
            ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom));
          n++;
        end
      endcase
    end
  endtask

  initial begin
    int unsigned shifts [5] = '{0, 20, 12, 4, 16};
    int unsigned windows [5] = '{65536, 1, 0, 4096, 300};
    logic [31:0] budgets [5] = '{32'hFFFF_FFFF, 32'd0, 32'd200000, 32'd1000000, 32'd5000};
    sender_hold = 0;
    receiver_hold = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    page_shift_q = 5'd12;
    window_q = 17'd1024;
    budget_q = 32'd1048576;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: commit with nothing pending, filters, extremes, wrap.
    pending_items.push_back(commit_item(17'd100, 32'd5));
    pending_items.push_back(consider_item(64'd0, 1'b1));
    pending_items.push_back(consider_item(64'd4095, 1'b1));
    pending_items.push_back(consider_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
    pending_items.push_back(consider_item(64'h0100_0000_0000_0000, 1'b1));
    pending_items.push_back(consider_item(64'h00FF_FFFF_FFFF_FFFF, 1'b0));
    pending_items.push_back(consider_item(64'h0000_0000_0010_0000, 1'b1));
    pending_items.push_back(commit_item(17'd0, 32'd7));
    pending_items.push_back(consider_item(64'h0000_0000_0010_0000, 1'b1));
    pending_items.push_back(commit_item(17'd512, 32'd0));
    pending_items.push_back(consider_item(64'h0000_0000_0010_0000, 1'b1));
    pending_items.push_back(consider_item(64'h0000_0000_0020_0000, 1'b1));
    pending_items.push_back(commit_item(17'h1FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(consider_item(64'h0000_0000_0020_0010, 1'b1));
    pending_items.push_back(consider_item(64'h00FF_FFFF_FFFF_FFFF, 1'b1));
    pending_items.push_back(commit_item(17'd1, 32'd1));
    wait_drained();

    foreach (shifts[p]) begin
      write_register(brct_pkg::RegPageShift, shifts[p]);
      write_register(brct_pkg::RegWindow, windows[p]);
      write_register(brct_pkg::RegBudget, budgets[p]);
      if (p == 1) begin
        // Stall the receiver long enough to back up the input.
        receiver_hold = 1;
        random_phase(20);
        repeat (600) @(posedge clk_i);
        receiver_hold = 0;
      end
      random_phase(175);
      wait_drained();
    end
    // Drive the table to its entry cap with small windows and a huge budget.
    write_register(brct_pkg::RegPageShift, 32'd0);
    write_register(brct_pkg::RegWindow, 32'd16);
    write_register(brct_pkg::RegBudget, 32'hFFFF_FFFF);
    for (int unsigned n = 0; n < 70; n++) begin
      pending_items.push_back(consider_item(64'h1000 + 64'(n) * 64'h100
                                            + 64'($urandom_range(0, 8)), 1'b1));
      pending_items.push_back(commit_item(17'd16, $urandom | 32'd1));
    end
    pending_items.push_back(consider_item(64'h0000_0000_0900_0000, 1'b1));
    wait_drained();

    if (mismatches == 0) $display("budgeted_region_capture_table regression: pass");
    else $display("budgeted_region_capture_table regression: fail");
    $finish;
  end
endmodule
